>>> design/lfu_cache_table_macros.svh
// assertion macros shared by the lfu cache table rtl
// expects clk and arst_n in scope where used
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lfu_pkg.sv
// shared constants for the lfu cache table
// no dependencies
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam int STAMP_BITS = 32;
	localparam int CAP_BITS   = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

endpackage

>>> design/lfu_victim_sel.sv
// victim selection: lowest use count, oldest touch on a tie, lower slot last
// depends on lfu_pkg
`timescale 1ns / 1ps

module lfu_victim_sel import lfu_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic [ENTRIES-1:0]    valid,
	input  logic [COUNT_BITS-1:0] cnt [ENTRIES],
	input  logic [STAMP_BITS-1:0] age [ENTRIES],
	output logic [IDX_W-1:0]      idx
);

	localparam int LEVELS = $clog2(ENTRIES);
	localparam int LEAVES = 1 << LEVELS;
	localparam int NODES  = 2 * LEAVES - 1;

	typedef struct packed {
		logic                  vld;
		logic [COUNT_BITS-1:0] cnt;
		logic [STAMP_BITS-1:0] age;
		logic [IDX_W-1:0]      idx;
	} node_t;

	node_t nd [NODES];

	for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
		if (g < ENTRIES) begin : g_real
			assign nd[LEAVES-1+g] = '{valid[g], cnt[g], age[g], IDX_W'(g)};
		end else begin : g_pad
			assign nd[LEAVES-1+g] = '{1'b0, '0, '0, '0};
		end
	end

	// left side holds the lower slots and keeps full ties
	for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
		logic right_better;
		assign right_better = nd[2*n+2].vld && (!nd[2*n+1].vld ||
			(nd[2*n+2].cnt < nd[2*n+1].cnt) ||
			((nd[2*n+2].cnt == nd[2*n+1].cnt) && (nd[2*n+2].age > nd[2*n+1].age)));
		assign nd[n] = right_better ? nd[2*n+2] : nd[2*n+1];
	end

	assign idx = nd[0].idx;

endmodule

>>> design/lfu_cache_table.sv
// a request is captured in the input register and its result is then registered in the result
// register; while the output stalls, the request waits in the input register
// throughput: one request per cycle unless the output stalls, with a combinational match and victim tree
// reset: all entries invalid, occupancy and touch counter zero, capacity 16
// top level of the lfu cache table, depends on lfu_pkg, lfu_victim_sel and the macro header
`timescale 1ns / 1ps
`include "lfu_cache_table_macros.svh"

module lfu_cache_table import lfu_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] write_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value,
	output logic                  evicted,
	output logic [KEY_BITS-1:0]   evicted_key,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CAP_BITS-1:0]   cfg_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

	// configuration
	logic [CAP_BITS-1:0] cap_q;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    cap_eff;

	// input stage
	logic                  valid_s1;
	logic                  op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] wval_s1;

	// cache state
	logic [ENTRIES-1:0]    entry_valid_q;
	logic [KEY_BITS-1:0]   entry_key_q   [ENTRIES];
	logic [VALUE_BITS-1:0] entry_value_q [ENTRIES];
	logic [COUNT_BITS-1:0] use_count_q   [ENTRIES];
	logic [STAMP_BITS-1:0] touch_stamp_q [ENTRIES];
	logic [OCC_W-1:0]      occ_q;
	logic [STAMP_BITS-1:0] stamp_q;

	// result register
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  evicted_q;
	logic [KEY_BITS-1:0]   evicted_key_q;

	// lookup and replacement
	logic                  advance;
	logic [ENTRIES-1:0]    match;
	logic                  hit_c;
	logic [IDX_W-1:0]      hit_idx;
	logic                  have_free;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      vict_idx;
	logic                  need_evict;
	logic [IDX_W-1:0]      ins_idx;
	logic [IDX_W-1:0]      wr_idx;
	logic                  do_write;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [STAMP_BITS-1:0] age [ENTRIES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// capacity zero acts as one, anything above the table size as the table size
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			key_s1  <= key;
			wval_s1 <= write_value;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = entry_valid_q[i] && (entry_key_q[i] == key_s1);
			age[i]   = stamp_q - touch_stamp_q[i];
		end
	end

	assign hit_c = |match;

	// lowest matching slot and lowest free slot
	always_comb begin
		hit_idx   = '0;
		free_idx  = '0;
		have_free = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!entry_valid_q[i]) begin
				free_idx  = IDX_W'(i);
				have_free = 1'b1;
			end
		end
	end

	lfu_victim_sel #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W)
	) u_victim (
		.valid (entry_valid_q),
		.cnt   (use_count_q),
		.age   (age),
		.idx   (vict_idx)
	);

	assign need_evict = (CMP_W'(occ_q) >= cap_eff) || !have_free;
	assign ins_idx    = need_evict ? vict_idx : free_idx;
	assign wr_idx     = hit_c ? hit_idx : ins_idx;
	assign do_write   = valid_s1 && advance && (hit_c || (op_s1 == OP_SET));

	// saturating bump on a hit, fresh count of one on insert
	always_comb begin
		if (!hit_c) begin
			cnt_next = COUNT_BITS'(1);
		end else if (&use_count_q[hit_idx]) begin
			cnt_next = use_count_q[hit_idx];
		end else begin
			cnt_next = use_count_q[hit_idx] + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			occ_q         <= '0;
			stamp_q       <= '0;
		end else if (do_write) begin
			entry_valid_q[wr_idx] <= 1'b1;
			stamp_q               <= stamp_q + STAMP_BITS'(1);
			if (!hit_c && !need_evict) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			entry_key_q[wr_idx]   <= key_s1;
			use_count_q[wr_idx]   <= cnt_next;
			touch_stamp_q[wr_idx] <= stamp_q;
			if (op_s1 == OP_SET) begin
				entry_value_q[wr_idx] <= wval_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			hit_q         <= hit_c;
			evicted_q     <= !hit_c && (op_s1 == OP_SET) && need_evict;
			evicted_key_q <= (!hit_c && (op_s1 == OP_SET) && need_evict) ?
				entry_key_q[vict_idx] : '0;
			if (op_s1 == OP_SET) begin
				read_value_q <= wval_s1;
			end else if (hit_c) begin
				read_value_q <= entry_value_q[hit_idx];
			end else begin
				read_value_q <= '1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	`LFU_ASSERT_NOW(a_occ_matches_valid, 1'b1, $countones(entry_valid_q) == occ_q, "occupancy out of step with valid entries")
	`LFU_ASSERT_NOW(a_occ_bounded, 1'b1, occ_q <= OCC_W'(ENTRIES), "occupancy above table size")
	`LFU_ASSERT_NOW(a_evict_not_hit, out_valid_q && evicted_q, !hit_q, "eviction reported on a hit")
	`LFU_ASSERT_NEXT(a_insert_valid, do_write && !hit_c, entry_valid_q[$past(ins_idx)], "inserted slot not valid")
	`LFU_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1, "input stalled with empty stage")

endmodule
